// ===== src/mau_pkg.sv =====
`timescale 1ns / 1ps
package mau_pkg;

	localparam int WORD_BITS = 32;
	localparam int CNT_W     = $clog2(WORD_BITS);

	// operation codes
	localparam logic [2:0] OP_ADD = 3'd0;
	localparam logic [2:0] OP_MUL = 3'd1;
	localparam logic [2:0] OP_NEG = 3'd2;
	localparam logic [2:0] OP_INV = 3'd3;
	localparam logic [2:0] OP_DIV = 3'd4;
	localparam logic [2:0] OP_RED = 3'd5;

	// status codes
	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_NOT_INV = 2'd1;
	localparam logic [1:0] ST_NO_SOL  = 2'd2;

	typedef enum logic {
		ALU_DIV,
		ALU_MUL
	} alu_op_t;

	typedef struct packed {
		logic    start;
		alu_op_t op;
	} alu_req_t;

	typedef struct packed {
		logic done;
	} alu_rsp_t;

endpackage

// ===== src/mau_if.sv =====
`timescale 1ns / 1ps
interface mau_in_if;
	logic        valid;
	logic        ready;
	logic [2:0]  operation;
	logic [31:0] operand_a;
	logic [31:0] operand_b;

	modport source (output valid, operation, operand_a, operand_b, input ready);
	modport sink (input valid, operation, operand_a, operand_b, output ready);
endinterface

interface mau_out_if;
	logic        valid;
	logic        ready;
	logic [31:0] result;
	logic [1:0]  status;

	modport source (output valid, result, status, input ready);
	modport sink (input valid, result, status, output ready);
endinterface

// ===== src/mau_alu.sv =====
`timescale 1ns / 1ps
module mau_alu (
	input  logic                          clk,
	input  logic                          arst_n,
	input  mau_pkg::alu_req_t             req,
	input  logic [mau_pkg::WORD_BITS-1:0] a,
	input  logic [mau_pkg::WORD_BITS-1:0] b,
	input  logic [mau_pkg::WORD_BITS-1:0] m,
	output mau_pkg::alu_rsp_t             rsp,
	output logic [mau_pkg::WORD_BITS-1:0] quo,
	output logic [mau_pkg::WORD_BITS-1:0] rem
);
	// div: a / m -> quo, rem; mul: a * b mod m -> rem (a, b < m)
	logic [mau_pkg::WORD_BITS-1:0] x_q, y_q, m_q, acc_q;
	logic [mau_pkg::CNT_W-1:0]     cnt_q;
	logic                          busy_q, done_q;
	mau_pkg::alu_op_t              op_q;

	logic [mau_pkg::WORD_BITS:0]   t_div, t_dbl, t_sum;
	logic [mau_pkg::WORD_BITS-1:0] d_nxt, dbl_m, m_nxt;
	logic                          ge;

	always_comb begin
		// restoring division step
		t_div = {acc_q, x_q[mau_pkg::WORD_BITS-1]};
		ge    = t_div >= {1'b0, m_q};
		d_nxt = ge ? mau_pkg::WORD_BITS'(t_div - {1'b0, m_q})
			: t_div[mau_pkg::WORD_BITS-1:0];
		// double and add modular step
		t_dbl = {acc_q, 1'b0};
		dbl_m = (t_dbl >= {1'b0, m_q}) ? mau_pkg::WORD_BITS'(t_dbl - {1'b0, m_q})
			: t_dbl[mau_pkg::WORD_BITS-1:0];
		t_sum = {1'b0, dbl_m} + {1'b0, x_q};
		if (!y_q[mau_pkg::WORD_BITS-1]) begin
			m_nxt = dbl_m;
		end else if (t_sum >= {1'b0, m_q}) begin
			m_nxt = mau_pkg::WORD_BITS'(t_sum - {1'b0, m_q});
		end else begin
			m_nxt = t_sum[mau_pkg::WORD_BITS-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == mau_pkg::CNT_W'(mau_pkg::WORD_BITS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			op_q  <= req.op;
			x_q   <= a;
			y_q   <= b;
			m_q   <= m;
			acc_q <= '0;
		end else if (busy_q) begin
			if (op_q == mau_pkg::ALU_DIV) begin
				x_q   <= {x_q[mau_pkg::WORD_BITS-2:0], ge};
				acc_q <= d_nxt;
			end else begin
				y_q   <= {y_q[mau_pkg::WORD_BITS-2:0], 1'b0};
				acc_q <= m_nxt;
			end
		end
	end

	assign rsp.done = done_q;
	assign quo      = x_q;
	assign rem      = acc_q;
endmodule

// ===== src/modular_arithmetic_unit.sv =====
`timescale 1ns / 1ps
// sequence: add, negate and reduce run two operand reductions; multiply adds one mul-mod pass;
// inverse runs a divide and a mul-mod per euclid step (up to ~47 steps), and
// divide runs two gcds, an inverse and one to seven more passes through the shared unit.
// throughput: one item at a time, set by the one bit-serial divide / mul-mod unit.
// reset: arst_n clears the sequencer and output beat, and sets the modulus to 2.
module modular_arithmetic_unit (
	input  logic        clk,
	input  logic        arst_n,
	mau_in_if.sink      req,
	mau_out_if.source   rsp,
	input  logic        cfg_we,
	input  logic [31:0] cfg_wdata
);
	localparam int W = mau_pkg::WORD_BITS;

	// sequencer states
	typedef enum logic [18:0] {
		S_IDLE     = 19'b1 << 0,
		S_RED_A    = 19'b1 << 1,
		S_RED_B    = 19'b1 << 2,
		S_DISPATCH = 19'b1 << 3,
		S_MUL      = 19'b1 << 4,
		S_GCD_TEST = 19'b1 << 5,
		S_GCD_DIV  = 19'b1 << 6,
		S_DV_MODG  = 19'b1 << 7,
		S_DV_BQ    = 19'b1 << 8,
		S_DV_M     = 19'b1 << 9,
		S_INV_TEST = 19'b1 << 10,
		S_INV_DIV  = 19'b1 << 11,
		S_INV_MUL  = 19'b1 << 12,
		S_INV_END  = 19'b1 << 13,
		S_DV_AQ    = 19'b1 << 14,
		S_DV_T     = 19'b1 << 15,
		S_DV_RES   = 19'b1 << 16,
		S_DV_CHK   = 19'b1 << 17,
		S_DONE     = 19'b1 << 18
	} state_t;

	state_t state_q;
	logic   iss_q;        // unit command issued for the current state
	logic   gsel_q;       // second gcd pass (modulus with b)
	logic   inv_div_q;    // inverse called from divide
	logic   ov_q;         // output beat pending
	logic [W-1:0] n_q;

	// working registers
	logic [2:0]   op_q;
	logic [W-1:0] a_q, b_q, r0_q, r1_q, t0_q, t1_q, ga_q, gb_q, gq_q;
	logic [W-1:0] im_q, qt_q, nr_q, res_q;
	logic [1:0]   st_q;
	logic [W-1:0] out_res_q;
	logic [1:0]   out_st_q;

	// shared unit
	mau_pkg::alu_req_t alu_req;
	mau_pkg::alu_rsp_t alu_rsp;
	logic [W-1:0]      alu_a, alu_b, alu_m, alu_quo, alu_rem;
	logic              alu_state;

	mau_alu u_alu (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (alu_req),
		.a      (alu_a),
		.b      (alu_b),
		.m      (alu_m),
		.rsp    (alu_rsp),
		.quo    (alu_quo),
		.rem    (alu_rem)
	);

	// small combinational helpers
	logic [W:0]   add_s;
	logic [W-1:0] add_res, neg_res, qmod, sub_res;

	always_comb begin
		add_s   = {1'b0, a_q} + {1'b0, b_q};
		add_res = (add_s >= {1'b0, n_q}) ? W'(add_s - {1'b0, n_q}) : add_s[W-1:0];
		neg_res = (a_q == '0) ? '0 : n_q - a_q;
		// euclid quotient can equal the modulus only on the first step
		qmod    = (qt_q == im_q) ? '0 : qt_q;
		sub_res = (t0_q >= alu_rem) ? t0_q - alu_rem : t0_q + (im_q - alu_rem);
	end

	// operand routing into the shared unit
	always_comb begin
		alu_state = 1'b1;
		alu_a     = a_q;
		alu_b     = b_q;
		alu_m     = n_q;
		alu_req.op = mau_pkg::ALU_DIV;
		case (state_q)
			S_RED_A: begin
				alu_a = a_q;
			end
			S_RED_B: begin
				alu_a = b_q;
			end
			S_MUL: begin
				alu_req.op = mau_pkg::ALU_MUL;
			end
			S_GCD_DIV, S_INV_DIV: begin
				alu_a = r0_q;
				alu_m = r1_q;
			end
			S_DV_MODG: begin
				alu_a = ga_q;
				alu_m = gb_q;
			end
			S_DV_BQ: begin
				alu_a = b_q;
				alu_m = gb_q;
			end
			S_DV_M: begin
				alu_a = n_q;
				alu_m = gb_q;
			end
			S_INV_MUL: begin
				alu_req.op = mau_pkg::ALU_MUL;
				alu_a = qmod;
				alu_b = t1_q;
				alu_m = im_q;
			end
			S_DV_AQ: begin
				alu_a = a_q;
				alu_m = ga_q;
			end
			S_DV_T: begin
				alu_req.op = mau_pkg::ALU_MUL;
				alu_a = t0_q;
				alu_b = gq_q;
			end
			S_DV_RES: begin
				alu_req.op = mau_pkg::ALU_MUL;
				alu_a = qt_q;
				alu_b = res_q;
			end
			S_DV_CHK: begin
				alu_req.op = mau_pkg::ALU_MUL;
				alu_a = b_q;
				alu_b = res_q;
			end
			default: begin
				alu_state = 1'b0;
			end
		endcase
		alu_req.start = alu_state && !iss_q;
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			iss_q     <= 1'b0;
			gsel_q    <= 1'b0;
			inv_div_q <= 1'b0;
			ov_q      <= 1'b0;
			n_q       <= W'(2);
		end else begin
			if (cfg_we) begin
				n_q <= cfg_wdata[W-1:0];
			end
			if (rsp.valid && rsp.ready) begin
				ov_q <= 1'b0;
			end
			if (alu_req.start) begin
				iss_q <= 1'b1;
			end else if (alu_rsp.done) begin
				iss_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (req.valid) begin
						// modulus 0 or 1: everything is zero
						state_q <= (n_q < W'(2)) ? S_DONE : S_RED_A;
					end
				end
				S_RED_A: begin
					if (alu_rsp.done) state_q <= S_RED_B;
				end
				S_RED_B: begin
					if (alu_rsp.done) state_q <= S_DISPATCH;
				end
				S_DISPATCH: begin
					case (op_q)
						mau_pkg::OP_MUL: state_q <= S_MUL;
						mau_pkg::OP_INV: begin
							inv_div_q <= 1'b0;
							state_q   <= S_INV_TEST;
						end
						mau_pkg::OP_DIV: begin
							gsel_q  <= 1'b0;
							state_q <= (a_q == '0) ? S_DONE : S_GCD_TEST;
						end
						default: state_q <= S_DONE;
					endcase
				end
				S_MUL: begin
					if (alu_rsp.done) state_q <= S_DONE;
				end
				S_GCD_TEST: begin
					if (r1_q != '0) begin
						state_q <= S_GCD_DIV;
					end else if (!gsel_q) begin
						gsel_q <= 1'b1;
					end else begin
						state_q <= S_DV_MODG;
					end
				end
				S_GCD_DIV: begin
					if (alu_rsp.done) state_q <= S_GCD_TEST;
				end
				S_DV_MODG: begin
					if (alu_rsp.done) state_q <= (alu_rem != '0) ? S_DONE : S_DV_BQ;
				end
				S_DV_BQ: begin
					if (alu_rsp.done) state_q <= S_DV_M;
				end
				S_DV_M: begin
					if (alu_rsp.done) begin
						inv_div_q <= 1'b1;
						state_q   <= S_INV_TEST;
					end
				end
				S_INV_TEST: begin
					state_q <= (r1_q == '0) ? S_INV_END : S_INV_DIV;
				end
				S_INV_DIV: begin
					if (alu_rsp.done) state_q <= S_INV_MUL;
				end
				S_INV_MUL: begin
					if (alu_rsp.done) state_q <= S_INV_TEST;
				end
				S_INV_END: begin
					state_q <= (r0_q == W'(1) && inv_div_q) ? S_DV_AQ : S_DONE;
				end
				S_DV_AQ: begin
					if (alu_rsp.done) state_q <= S_DV_T;
				end
				S_DV_T: begin
					if (alu_rsp.done) state_q <= S_DV_RES;
				end
				S_DV_RES: begin
					if (alu_rsp.done) state_q <= S_DV_CHK;
				end
				S_DV_CHK: begin
					if (alu_rsp.done) state_q <= S_DONE;
				end
				S_DONE: begin
					if (!ov_q || rsp.ready) begin
						ov_q    <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				op_q  <= req.operation;
				a_q   <= req.operand_a[W-1:0];
				b_q   <= req.operand_b[W-1:0];
				res_q <= '0;
				st_q  <= mau_pkg::ST_OK;
			end
			S_RED_A: begin
				if (alu_rsp.done) a_q <= alu_rem;
			end
			S_RED_B: begin
				if (alu_rsp.done) b_q <= alu_rem;
			end
			S_DISPATCH: begin
				case (op_q)
					mau_pkg::OP_ADD: res_q <= add_res;
					mau_pkg::OP_NEG: res_q <= neg_res;
					mau_pkg::OP_RED: res_q <= a_q;
					mau_pkg::OP_INV: begin
						im_q <= n_q;
						r0_q <= n_q;
						r1_q <= a_q;
						t0_q <= '0;
						t1_q <= W'(1);
					end
					mau_pkg::OP_DIV: begin
						r0_q <= n_q;
						r1_q <= a_q;
					end
					default: res_q <= '0;
				endcase
			end
			S_MUL: begin
				if (alu_rsp.done) res_q <= alu_rem;
			end
			S_GCD_TEST: begin
				if (r1_q == '0) begin
					if (!gsel_q) begin
						ga_q <= r0_q;
						r0_q <= n_q;
						r1_q <= b_q;
					end else begin
						gb_q <= r0_q;
					end
				end
			end
			S_GCD_DIV: begin
				if (alu_rsp.done) begin
					r0_q <= r1_q;
					r1_q <= alu_rem;
				end
			end
			S_DV_MODG: begin
				if (alu_rsp.done) begin
					gq_q <= alu_quo;
					if (alu_rem != '0) st_q <= mau_pkg::ST_NO_SOL;
				end
			end
			S_DV_BQ: begin
				if (alu_rsp.done) nr_q <= alu_quo;
			end
			S_DV_M: begin
				if (alu_rsp.done) begin
					im_q <= alu_quo;
					r0_q <= alu_quo;
					r1_q <= nr_q;
					t0_q <= '0;
					t1_q <= (alu_quo == W'(1)) ? '0 : W'(1);
				end
			end
			S_INV_DIV: begin
				if (alu_rsp.done) begin
					qt_q <= alu_quo;
					nr_q <= alu_rem;
				end
			end
			S_INV_MUL: begin
				if (alu_rsp.done) begin
					t1_q <= sub_res;
					t0_q <= t1_q;
					r0_q <= r1_q;
					r1_q <= nr_q;
				end
			end
			S_INV_END: begin
				if (r0_q != W'(1)) begin
					res_q <= '0;
					st_q  <= inv_div_q ? mau_pkg::ST_NO_SOL : mau_pkg::ST_NOT_INV;
				end else if (!inv_div_q) begin
					res_q <= t0_q;
				end
			end
			S_DV_AQ: begin
				if (alu_rsp.done) qt_q <= alu_quo;
			end
			S_DV_T, S_DV_RES: begin
				if (alu_rsp.done) res_q <= alu_rem;
			end
			S_DV_CHK: begin
				if (alu_rsp.done && alu_rem != a_q) begin
					res_q <= '0;
					st_q  <= mau_pkg::ST_NO_SOL;
				end
			end
			S_DONE: begin
				if (!ov_q || rsp.ready) begin
					out_res_q <= res_q;
					out_st_q  <= st_q;
				end
			end
			default: begin
			end
		endcase
	end

	assign req.ready  = (state_q == S_IDLE);
	assign rsp.valid  = ov_q;
	assign rsp.result = 32'(out_res_q);
	assign rsp.status = out_st_q;
endmodule

// ===== src/mau_checker.sv =====
`timescale 1ns / 1ps
module mau_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [31:0] result,
	input logic [1:0]  status
);
	// one item in flight: no beat taken right after another
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input taken while busy");

	// stalled output beat holds
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(result) && $stable(status))
		else $error("output beat changed under stall");

	// errors carry a zero result
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != mau_pkg::ST_OK |-> result == '0)
		else $error("nonzero result with error status");

	// no undefined status code
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> status == mau_pkg::ST_OK || status == mau_pkg::ST_NOT_INV
			|| status == mau_pkg::ST_NO_SOL)
		else $error("bad status code");
endmodule

bind modular_arithmetic_unit mau_checker u_mau_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (req.valid),
	.in_ready  (req.ready),
	.out_valid (rsp.valid),
	.out_ready (rsp.ready),
	.result    (rsp.result),
	.status    (rsp.status)
);
